@@ hdl/tetrahedron_circumcenter_defines.svh @@
// Assertion macros for the RTL of the tetrahedron circumcenter block.
`ifndef TETRAHEDRON_CIRCUMCENTER_DEFINES_SVH
`define TETRAHEDRON_CIRCUMCENTER_DEFINES_SVH

`ifndef SYNTH
`define TCC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define TCC_ASSERT_DELAY(lbl, clk, rst_n, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
    else $error(msg);
`else
`define TCC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define TCC_ASSERT_DELAY(lbl, clk, rst_n, ante, dly, cons, msg)
`endif

`endif

@@ hdl/tcc_pkg.sv @@
`default_nettype none

package tcc_pkg;

  localparam int COORD_BITS       = 16;
  localparam int CENTER_FRAC_BITS = 8;
  localparam int COORD_FRAC_BITS  = 16;
  localparam int OUT_W            = 32;

  // Exact widths of the intermediate integers.
  localparam int E_W    = COORD_BITS + 1;
  localparam int PR_W   = 2 * E_W;
  localparam int CR_W   = 2 * E_W + 1;
  localparam int LEN_W  = 2 * E_W + 2;
  localparam int D_W    = E_W + CR_W + 2;
  localparam int D2_W   = D_W + 1;
  localparam int N_W    = LEN_W + CR_W + 2;
  localparam int CN_W   = N_W + 1;
  localparam int XN_W   = N_W + CR_W + 2;
  localparam int DEN_W  = 2 * D_W + 1;
  localparam int NUM_W  = XN_W + COORD_FRAC_BITS;

  // Operand splits that keep each multiplier near 32 by 32 bits.
  localparam int NL_W   = (N_W + 1) / 2;
  localparam int NH_W   = N_W - NL_W;
  localparam int PL_W   = NL_W + 1 + CR_W;
  localparam int PH_W   = NH_W + CR_W;
  localparam int DL_W   = D_W / 2;
  localparam int DH_W   = D_W - DL_W;
  localparam int HH_W   = 2 * DH_W;
  localparam int HL_W   = DH_W + DL_W + 1;
  localparam int LL_W   = 2 * DL_W + 2;

  localparam int QUO_W        = OUT_W;
  localparam int DIV_STAGES   = QUO_W;
  localparam int FRONT_STAGES = 5;
  localparam int LATENCY      = FRONT_STAGES + DIV_STAGES + 3;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic valid;
    logic degen;
  } ctl_t;

endpackage

`default_nettype wire

@@ hdl/tetrahedron_circumcenter.sv @@
`default_nettype none
`include "tetrahedron_circumcenter_defines.svh"

// Tetrahedron circumcenter. Each beat carries the four vertices a, b, c, d as
// signed 16-bit integers and yields exactly one result beat: the absolute
// circumcenter in Q24.8 and the xi, eta, zeta coordinates along edges ab, ac
// and ad in Q16.16. Every value is the exact quotient, truncated toward zero
// and saturated to the signed 32-bit range. When the four points are coplanar
// the determinant is zero, degenerate is set and all other result fields are
// zero. A beat is accepted on any clock edge where start is high; busy never
// rises, so the block takes one tetrahedron every cycle with no gaps. Each
// result appears on done_o exactly 40 cycles after its beat was accepted, in
// input order, and is held for that single cycle only: the receiver cannot
// stall the block, so it must capture every done_o beat as it comes. The
// latency is set by the five-stage arithmetic front end (edges, cross products,
// determinant and numerators, partial products, recombination) followed by six
// parallel restoring dividers that resolve one quotient bit per stage over 32
// stages, plus a setup stage, a saturation stage and the output register.
module tetrahedron_circumcenter (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    start,
  output logic                                    busy,
  input  logic signed [tcc_pkg::COORD_BITS-1:0]   a_x_i,
  input  logic signed [tcc_pkg::COORD_BITS-1:0]   a_y_i,
  input  logic signed [tcc_pkg::COORD_BITS-1:0]   a_z_i,
  input  logic signed [tcc_pkg::COORD_BITS-1:0]   b_x_i,
  input  logic signed [tcc_pkg::COORD_BITS-1:0]   b_y_i,
  input  logic signed [tcc_pkg::COORD_BITS-1:0]   b_z_i,
  input  logic signed [tcc_pkg::COORD_BITS-1:0]   c_x_i,
  input  logic signed [tcc_pkg::COORD_BITS-1:0]   c_y_i,
  input  logic signed [tcc_pkg::COORD_BITS-1:0]   c_z_i,
  input  logic signed [tcc_pkg::COORD_BITS-1:0]   d_x_i,
  input  logic signed [tcc_pkg::COORD_BITS-1:0]   d_y_i,
  input  logic signed [tcc_pkg::COORD_BITS-1:0]   d_z_i,
  output logic                                    done_o,
  output logic signed [tcc_pkg::OUT_W-1:0]        center_x_o,
  output logic signed [tcc_pkg::OUT_W-1:0]        center_y_o,
  output logic signed [tcc_pkg::OUT_W-1:0]        center_z_o,
  output logic signed [tcc_pkg::OUT_W-1:0]        coord_xi_o,
  output logic signed [tcc_pkg::OUT_W-1:0]        coord_eta_o,
  output logic signed [tcc_pkg::OUT_W-1:0]        coord_zeta_o,
  output logic                                    degenerate_o
);
  import tcc_pkg::*;

  // Cycles from a valid front-end output to the matching done_o beat.
  localparam int OUT_TAIL = DIV_STAGES + 3;

  logic   accept;
  coord_t pt [4][3];

  logic signed [CN_W-1:0]  cnum [3];
  logic signed [D2_W-1:0]  d2;
  logic signed [XN_W-1:0]  xnum [3];
  logic signed [DEN_W-1:0] den;
  ctl_t                    front_ctl;

  logic signed [NUM_W-1:0] cdiv_num [3];
  logic signed [NUM_W-1:0] xdiv_num [3];
  logic signed [OUT_W-1:0] center_res [3];
  logic signed [OUT_W-1:0] coord_res [3];

  // Control travels beside the dividers: setup, 32 bit stages and saturation.
  ctl_t ctl_q [DIV_STAGES+2];

  logic                    done_q;
  logic                    degen_q;
  logic signed [OUT_W-1:0] center_q [3];
  logic signed [OUT_W-1:0] coord_q [3];

  // The pipeline never stalls, so a new beat is always welcome.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign pt[0][0] = a_x_i;
  assign pt[0][1] = a_y_i;
  assign pt[0][2] = a_z_i;
  assign pt[1][0] = b_x_i;
  assign pt[1][1] = b_y_i;
  assign pt[1][2] = b_z_i;
  assign pt[2][0] = c_x_i;
  assign pt[2][1] = c_y_i;
  assign pt[2][2] = c_z_i;
  assign pt[3][0] = d_x_i;
  assign pt[3][1] = d_y_i;
  assign pt[3][2] = d_z_i;

  tcc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .pt_i    (pt),
    .cnum_o  (cnum),
    .d2_o    (d2),
    .xnum_o  (xnum),
    .den_o   (den),
    .ctl_o   (front_ctl)
  );

  // The center divides (a*2D + N) by 2D; the coordinates divide N.cross by 2D^2.
  for (genvar k = 0; k < 3; k++) begin : g_lane
    assign cdiv_num[k] = NUM_W'(cnum[k]) <<< CENTER_FRAC_BITS;
    assign xdiv_num[k] = NUM_W'(xnum[k]) <<< COORD_FRAC_BITS;

    tcc_div u_center_div (
      .clk_i (clk_i),
      .num_i (cdiv_num[k]),
      .den_i (DEN_W'(d2)),
      .res_o (center_res[k])
    );

    tcc_div u_coord_div (
      .clk_i (clk_i),
      .num_i (xdiv_num[k]),
      .den_i (den),
      .res_o (coord_res[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < DIV_STAGES + 2; s++) begin
        ctl_q[s] <= '0;
      end
      done_q <= 1'b0;
    end else begin
      ctl_q[0] <= front_ctl;
      for (int s = 1; s < DIV_STAGES + 2; s++) begin
        ctl_q[s] <= ctl_q[s-1];
      end
      done_q <= ctl_q[DIV_STAGES+1].valid;
    end
  end

  // A degenerate tetrahedron forces every numeric field to zero.
  always_ff @(posedge clk_i) begin
    degen_q <= ctl_q[DIV_STAGES+1].degen;
    for (int k = 0; k < 3; k++) begin
      center_q[k] <= ctl_q[DIV_STAGES+1].degen ? '0 : center_res[k];
      coord_q[k]  <= ctl_q[DIV_STAGES+1].degen ? '0 : coord_res[k];
    end
  end

  assign done_o       = done_q;
  assign degenerate_o = degen_q;
  assign center_x_o   = center_q[0];
  assign center_y_o   = center_q[1];
  assign center_z_o   = center_q[2];
  assign coord_xi_o   = coord_q[0];
  assign coord_eta_o  = coord_q[1];
  assign coord_zeta_o = coord_q[2];

  // A degenerate result carries zeros in its center, xi and zeta fields.
  `TCC_ASSERT_IMPL(a_degen_zero, clk_i, rst_ni, done_o && degenerate_o, center_x_o == '0 && center_y_o == '0 && center_z_o == '0 && coord_xi_o == '0 && coord_zeta_o == '0, "degenerate beat with nonzero fields")
  // Every item leaving the front end reaches the output after the divider chain.
  `TCC_ASSERT_DELAY(a_front_to_out, clk_i, rst_ni, front_ctl.valid, OUT_TAIL, done_o, "front-end item lost in divider chain")
  // An accepted beat appears as a result after the fixed latency.
  `TCC_ASSERT_DELAY(a_latency, clk_i, rst_ni, accept, LATENCY, done_o, "result missing at fixed latency")
  // Coinciding vertices a and b always make the tetrahedron degenerate.
  `TCC_ASSERT_DELAY(a_flat_degen, clk_i, rst_ni, accept && a_x_i == b_x_i && a_y_i == b_y_i && a_z_i == b_z_i, LATENCY, degenerate_o, "coincident vertices not flagged")

endmodule

`default_nettype wire

@@ hdl/tcc_front.sv @@
`default_nettype none

module tcc_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  tcc_pkg::coord_t                   pt_i [4][3],
  output logic signed [tcc_pkg::CN_W-1:0]   cnum_o [3],
  output logic signed [tcc_pkg::D2_W-1:0]   d2_o,
  output logic signed [tcc_pkg::XN_W-1:0]   xnum_o [3],
  output logic signed [tcc_pkg::DEN_W-1:0]  den_o,
  output tcc_pkg::ctl_t                     ctl_o
);
  import tcc_pkg::*;

  logic v1_q, v2_q, v3_q;
  ctl_t ctl4_q, ctl5_q;

  // Stage 1: edge vectors.
  logic signed [E_W-1:0]   e1_q [3][3];
  coord_t                  a1_q [3];
  // Stage 2: cross products and squared lengths.
  logic signed [PR_W-1:0]  xp_a [3][3];
  logic signed [PR_W-1:0]  xp_b [3][3];
  logic signed [PR_W-1:0]  sq   [3][3];
  logic signed [CR_W-1:0]  cr_d [3][3];
  logic signed [LEN_W-1:0] len_d [3];
  logic signed [E_W-1:0]   e2_q [3][3];
  logic signed [CR_W-1:0]  cr2_q [3][3];
  logic signed [LEN_W-1:0] len2_q [3];
  coord_t                  a2_q [3];
  // Stage 3: determinant and the numerator vector.
  logic signed [D_W-1:0]   dp [3];
  logic signed [N_W-1:0]   np [3][3];
  logic signed [D_W-1:0]   d_d;
  logic signed [N_W-1:0]   n_d [3];
  logic signed [D_W-1:0]   d3_q;
  logic signed [N_W-1:0]   n3_q [3];
  logic signed [CR_W-1:0]  cr3_q [3][3];
  coord_t                  a3_q [3];
  // Stage 4: center numerators and partial products.
  logic signed [D2_W-1:0]  d2_d;
  logic signed [CN_W-1:0]  cnum_d [3];
  logic signed [PL_W-1:0]  pl_d [3][3];
  logic signed [PH_W-1:0]  ph_d [3][3];
  logic signed [DH_W-1:0]  dh;
  logic signed [DL_W:0]    dl;
  logic signed [HH_W-1:0]  hh_d;
  logic signed [HL_W-1:0]  hl_d;
  logic signed [LL_W-1:0]  ll_d;
  logic signed [CN_W-1:0]  cnum4_q [3];
  logic signed [D2_W-1:0]  d2_4_q;
  logic signed [PL_W-1:0]  pl4_q [3][3];
  logic signed [PH_W-1:0]  ph4_q [3][3];
  logic signed [HH_W-1:0]  hh4_q;
  logic signed [HL_W-1:0]  hl4_q;
  logic signed [LL_W-1:0]  ll4_q;
  // Stage 5: coordinate numerators and the shared denominator.
  logic signed [XN_W-1:0]  xnum_d [3];
  logic signed [DEN_W-1:0] den_d;
  logic signed [CN_W-1:0]  cnum5_q [3];
  logic signed [D2_W-1:0]  d2_5_q;
  logic signed [XN_W-1:0]  xnum5_q [3];
  logic signed [DEN_W-1:0] den5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      ctl4_q <= '0;
      ctl5_q <= '0;
    end else begin
      v1_q         <= valid_i;
      v2_q         <= v1_q;
      v3_q         <= v2_q;
      ctl4_q.valid <= v3_q;
      ctl4_q.degen <= (d3_q == '0);
      ctl5_q       <= ctl4_q;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        xp_a[i][k] = e1_q[(i + 1) % 3][(k + 1) % 3] * e1_q[(i + 2) % 3][(k + 2) % 3];
        xp_b[i][k] = e1_q[(i + 2) % 3][(k + 1) % 3] * e1_q[(i + 1) % 3][(k + 2) % 3];
        sq[i][k]   = e1_q[i][k] * e1_q[i][k];
        cr_d[i][k] = CR_W'(xp_a[i][k]) - CR_W'(xp_b[i][k]);
      end
      len_d[i] = LEN_W'(sq[i][0]) + LEN_W'(sq[i][1]) + LEN_W'(sq[i][2]);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dp[k] = e2_q[0][k] * cr2_q[0][k];
      for (int i = 0; i < 3; i++) begin
        np[i][k] = len2_q[i] * cr2_q[i][k];
      end
      n_d[k] = np[0][k] + np[1][k] + np[2][k];
    end
    d_d = dp[0] + dp[1] + dp[2];
  end

  always_comb begin
    d2_d = D2_W'(d3_q) <<< 1;
    for (int k = 0; k < 3; k++) begin
      cnum_d[k] = a3_q[k] * d2_d + n3_q[k];
      for (int i = 0; i < 3; i++) begin
        pl_d[i][k] = $signed({1'b0, n3_q[k][NL_W-1:0]}) * cr3_q[i][k];
        ph_d[i][k] = $signed(n3_q[k][N_W-1:NL_W]) * cr3_q[i][k];
      end
    end
    dh   = $signed(d3_q[D_W-1:DL_W]);
    dl   = $signed({1'b0, d3_q[DL_W-1:0]});
    hh_d = dh * dh;
    hl_d = dh * dl;
    ll_d = dl * dl;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      xnum_d[i] = '0;
      for (int k = 0; k < 3; k++) begin
        xnum_d[i] = xnum_d[i] + (XN_W'(ph4_q[i][k]) <<< NL_W) + XN_W'(pl4_q[i][k]);
      end
    end
    // 2*D*D rebuilt from the split halves of D.
    den_d = (DEN_W'(hh4_q) <<< (2 * DL_W + 1)) + (DEN_W'(hl4_q) <<< (DL_W + 2))
          + (DEN_W'(ll4_q) <<< 1);
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      a1_q[k] <= pt_i[0][k];
      a2_q[k] <= a1_q[k];
      a3_q[k] <= a2_q[k];
      n3_q[k] <= n_d[k];
      cnum4_q[k] <= cnum_d[k];
      cnum5_q[k] <= cnum4_q[k];
      xnum5_q[k] <= xnum_d[k];
      len2_q[k] <= len_d[k];
      for (int i = 0; i < 3; i++) begin
        e1_q[i][k]  <= E_W'(pt_i[i + 1][k]) - E_W'(pt_i[0][k]);
        e2_q[i][k]  <= e1_q[i][k];
        cr2_q[i][k] <= cr_d[i][k];
        cr3_q[i][k] <= cr2_q[i][k];
        pl4_q[i][k] <= pl_d[i][k];
        ph4_q[i][k] <= ph_d[i][k];
      end
    end
    d3_q   <= d_d;
    d2_4_q <= d2_d;
    d2_5_q <= d2_4_q;
    hh4_q  <= hh_d;
    hl4_q  <= hl_d;
    ll4_q  <= ll_d;
    den5_q <= den_d;
  end

  assign cnum_o = cnum5_q;
  assign d2_o   = d2_5_q;
  assign xnum_o = xnum5_q;
  assign den_o  = den5_q;
  assign ctl_o  = ctl5_q;

endmodule

`default_nettype wire

@@ hdl/tcc_div.sv @@
`default_nettype none

module tcc_div (
  input  logic                              clk_i,
  input  logic signed [tcc_pkg::NUM_W-1:0]  num_i,
  input  logic signed [tcc_pkg::DEN_W-1:0]  den_i,
  output logic signed [tcc_pkg::OUT_W-1:0]  res_o
);
  import tcc_pkg::*;

  localparam int CMP_W = NUM_W + DEN_W;
  localparam logic [OUT_W-1:0] MAX_POS = {1'b0, {(OUT_W - 1){1'b1}}};
  localparam logic [OUT_W-1:0] MIN_NEG = {1'b1, {(OUT_W - 1){1'b0}}};

  logic [NUM_W-1:0]       n_mag;
  logic [DEN_W-1:0]       d_mag;
  logic [NUM_W-QUO_W-1:0] n_top;
  logic                   big;

  logic [DEN_W-1:0] r_q   [DIV_STAGES+1];
  logic [QUO_W-1:0] lo_q  [DIV_STAGES+1];
  logic [QUO_W-1:0] q_q   [DIV_STAGES+1];
  logic [DEN_W-1:0] d_q   [DIV_STAGES+1];
  logic             neg_q [DIV_STAGES+1];
  logic             big_q [DIV_STAGES+1];

  logic [OUT_W-1:0] res_d;
  logic [OUT_W-1:0] res_q;

  // The quotient overflows 32 bits exactly when the top of the numerator reaches
  // the divisor; otherwise that top part is a valid starting remainder.
  always_comb begin
    n_mag = num_i[NUM_W-1] ? -num_i : num_i;
    d_mag = den_i[DEN_W-1] ? -den_i : den_i;
    n_top = n_mag[NUM_W-1:QUO_W];
    big   = CMP_W'(n_top) >= CMP_W'(d_mag);
  end

  always_ff @(posedge clk_i) begin
    r_q[0]   <= DEN_W'(n_top);
    lo_q[0]  <= n_mag[QUO_W-1:0];
    q_q[0]   <= '0;
    d_q[0]   <= d_mag;
    neg_q[0] <= num_i[NUM_W-1] ^ den_i[DEN_W-1];
    big_q[0] <= big;
  end

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_step
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;
    logic [DEN_W-1:0] r_d;

    always_comb begin
      trial = {r_q[s], lo_q[s][QUO_W-1]};
      diff  = trial - {1'b0, d_q[s]};
      fits  = trial >= {1'b0, d_q[s]};
      r_d   = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end

    always_ff @(posedge clk_i) begin
      r_q[s+1]   <= r_d;
      lo_q[s+1]  <= {lo_q[s][QUO_W-2:0], 1'b0};
      q_q[s+1]   <= {q_q[s][QUO_W-2:0], fits};
      d_q[s+1]   <= d_q[s];
      neg_q[s+1] <= neg_q[s];
      big_q[s+1] <= big_q[s];
    end
  end

  always_comb begin
    if (!neg_q[DIV_STAGES]) begin
      if (big_q[DIV_STAGES] || q_q[DIV_STAGES] > MAX_POS) begin
        res_d = MAX_POS;
      end else begin
        res_d = q_q[DIV_STAGES];
      end
    end else begin
      if (big_q[DIV_STAGES] || q_q[DIV_STAGES] > MIN_NEG) begin
        res_d = MIN_NEG;
      end else begin
        res_d = -q_q[DIV_STAGES];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

@@ tb/tetrahedron_circumcenter_tb.sv @@
`timescale 1ns / 100ps

module tetrahedron_circumcenter_tb;

  import tcc_pkg::*;

  // Wide enough for every exact intermediate, shifts included.
  typedef logic signed [255:0] big_t;

  // One tetrahedron beat plus the sender's behavior around it.
  typedef struct {
    coord_t p[12];   // a_x a_y a_z b_x ... d_z
    int     gap;     // idle cycles after this beat is accepted
    bit     drain;   // hold this beat until every pending result has come
  } tet_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] cx;
    logic signed [OUT_W-1:0] cy;
    logic signed [OUT_W-1:0] cz;
    logic signed [OUT_W-1:0] xi;
    logic signed [OUT_W-1:0] eta;
    logic signed [OUT_W-1:0] zeta;
    logic                    degen;
  } center_t;

  localparam int IDLE_LIMIT = 4000;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  logic done_o;
  logic signed [OUT_W-1:0] center_x_o, center_y_o, center_z_o;
  logic signed [OUT_W-1:0] coord_xi_o, coord_eta_o, coord_zeta_o;
  logic degenerate_o;

  coord_t drive_p[12];

  tet_t    pending_tets[$];
  center_t expected_centers[$];
  int      mismatches;
  int      stray_results;
  int      gap_left;
  int      idle_cycles;

  tetrahedron_circumcenter DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .a_x_i        (drive_p[0]),
    .a_y_i        (drive_p[1]),
    .a_z_i        (drive_p[2]),
    .b_x_i        (drive_p[3]),
    .b_y_i        (drive_p[4]),
    .b_z_i        (drive_p[5]),
    .c_x_i        (drive_p[6]),
    .c_y_i        (drive_p[7]),
    .c_z_i        (drive_p[8]),
    .d_x_i        (drive_p[9]),
    .d_y_i        (drive_p[10]),
    .d_z_i        (drive_p[11]),
    .done_o       (done_o),
    .center_x_o   (center_x_o),
    .center_y_o   (center_y_o),
    .center_z_o   (center_z_o),
    .coord_xi_o   (coord_xi_o),
    .coord_eta_o  (coord_eta_o),
    .coord_zeta_o (coord_zeta_o),
    .degenerate_o (degenerate_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Clamp an exact quotient to the signed 32-bit output range.
  function automatic logic signed [OUT_W-1:0] sat32(big_t q);
    if (q > big_t'(64'sh7FFFFFFF)) begin
      return 32'h7FFFFFFF;
    end
    if (q < -big_t'(64'sh80000000)) begin
      return 32'h80000000;
    end
    return q[OUT_W-1:0];
  endfunction

  // Exact circumcenter. Division of signed vectors truncates toward zero,
  // which is the rounding the block uses.
  function automatic center_t circumcenter(coord_t p[12]);
    big_t    v[4][3];
    big_t    e[3][3];
    big_t    len[3];
    big_t    cr[3][3];
    big_t    nv[3];
    big_t    det, two_det, den, num;
    center_t r;
    int      i, k, u, w;
    for (i = 0; i < 4; i++) begin
      for (k = 0; k < 3; k++) begin
        v[i][k] = big_t'(p[i * 3 + k]);
      end
    end
    for (i = 0; i < 3; i++) begin
      for (k = 0; k < 3; k++) begin
        e[i][k] = v[i + 1][k] - v[0][k];
      end
      len[i] = e[i][0] * e[i][0] + e[i][1] * e[i][1] + e[i][2] * e[i][2];
    end
    // cr[0] = ca x da, cr[1] = da x ba, cr[2] = ba x ca.
    for (i = 0; i < 3; i++) begin
      u = (i + 1) % 3;
      w = (i + 2) % 3;
      cr[i][0] = e[u][1] * e[w][2] - e[w][1] * e[u][2];
      cr[i][1] = e[u][2] * e[w][0] - e[w][2] * e[u][0];
      cr[i][2] = e[u][0] * e[w][1] - e[w][0] * e[u][1];
    end
    det = e[0][0] * cr[0][0] + e[0][1] * cr[0][1] + e[0][2] * cr[0][2];
    r = '0;
    if (det == 0) begin
      r.degen = 1'b1;
      return r;
    end
    two_det = det + det;
    for (k = 0; k < 3; k++) begin
      nv[k] = len[0] * cr[0][k] + len[1] * cr[1][k] + len[2] * cr[2][k];
    end
    r.cx = sat32(((v[0][0] * two_det + nv[0]) <<< CENTER_FRAC_BITS) / two_det);
    r.cy = sat32(((v[0][1] * two_det + nv[1]) <<< CENTER_FRAC_BITS) / two_det);
    r.cz = sat32(((v[0][2] * two_det + nv[2]) <<< CENTER_FRAC_BITS) / two_det);
    den = two_det * det;
    num = nv[0] * cr[0][0] + nv[1] * cr[0][1] + nv[2] * cr[0][2];
    r.xi = sat32((num <<< COORD_FRAC_BITS) / den);
    num = nv[0] * cr[1][0] + nv[1] * cr[1][1] + nv[2] * cr[1][2];
    r.eta = sat32((num <<< COORD_FRAC_BITS) / den);
    num = nv[0] * cr[2][0] + nv[1] * cr[2][1] + nv[2] * cr[2][2];
    r.zeta = sat32((num <<< COORD_FRAC_BITS) / den);
    return r;
  endfunction

  function automatic coord_t rand_range(int lo, int hi);
    return coord_t'(lo + int'($urandom_range(hi - lo)));
  endfunction

  // Random tetrahedron. Half are compact clusters of moderate size so the
  // results mostly land inside the output range; the rest stress the extremes or are coplanar.
  function automatic tet_t random_tet();
    tet_t t;
    int   mode, base, span, s, q, k;
    mode = $urandom_range(9);
    if (mode < 3) begin
      // Full range: exercises every input bit and mostly saturates.
      for (k = 0; k < 12; k++) begin
        t.p[k] = coord_t'($urandom);
      end
    end else if (mode < 8) begin
      // Compact cluster around a random origin.
      span = 1 << $urandom_range(12, 1);
      for (k = 0; k < 3; k++) begin
        base = int'(rand_range(-20000, 20000));
        t.p[k] = coord_t'(base);
        t.p[3 + k] = coord_t'(base + int'(rand_range(-span, span)));
        t.p[6 + k] = coord_t'(base + int'(rand_range(-span, span)));
        t.p[9 + k] = coord_t'(base + int'(rand_range(-span, span)));
      end
    end else begin
      // Coplanar: d = a + s*(b-a) + q*(c-a), so the determinant is zero.
      s = $urandom_range(4) - 2;
      q = $urandom_range(4) - 2;
      for (k = 0; k < 9; k++) begin
        t.p[k] = rand_range(-3000, 3000);
      end
      for (k = 0; k < 3; k++) begin
        t.p[9 + k] = coord_t'(int'(t.p[k]) + s * (int'(t.p[3 + k]) - int'(t.p[k]))
                              + q * (int'(t.p[6 + k]) - int'(t.p[k])));
      end
    end
    t.gap = 0;
    t.drain = 1'b0;
    return t;
  endfunction

  function automatic tet_t make_tet(int ax, int ay, int az, int bx, int by, int bz,
                                    int cx, int cy, int cz, int dx, int dy, int dz);
    tet_t t;
    t.p = '{coord_t'(ax), coord_t'(ay), coord_t'(az), coord_t'(bx), coord_t'(by),
            coord_t'(bz), coord_t'(cx), coord_t'(cy), coord_t'(cz), coord_t'(dx),
            coord_t'(dy), coord_t'(dz)};
    t.gap = 0;
    t.drain = 1'b0;
    return t;
  endfunction

  // Driver: a beat moves at an edge where start is high and busy is low.
  // Everything is decided with blocking variables so start and the coordinates
  // each get a single nonblocking update per edge.
  always @(posedge clk_i) begin
    tet_t nxt;
    bit   beat;
    if (!rst_ni) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      beat = start && !busy;
      if (beat) begin
        expected_centers.push_back(circumcenter(drive_p));
      end
      if (start && !beat) begin
        // Hold the beat until the block takes it.
      end else if (gap_left != 0) begin
        gap_left = gap_left - 1;
        start <= 1'b0;
      end else if (pending_tets.size() != 0 &&
                   !(pending_tets[0].drain && expected_centers.size() != 0)) begin
        nxt = pending_tets.pop_front();
        drive_p <= nxt.p;
        gap_left = nxt.gap;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every done_o beat must match the oldest prediction.
  always @(posedge clk_i) begin
    center_t got, want;
    if (rst_ni && done_o) begin
      got = '{center_x_o, center_y_o, center_z_o, coord_xi_o, coord_eta_o,
              coord_zeta_o, degenerate_o};
      if (expected_centers.size() == 0) begin
        stray_results++;
        $display("Unexpected result beat at %0t", $realtime);
      end else begin
        want = expected_centers.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch at %0t: expected cx=%0d cy=%0d cz=%0d xi=%0d eta=%0d zeta=%0d deg=%0b",
                     $realtime, want.cx, want.cy, want.cz, want.xi, want.eta, want.zeta,
                     want.degen);
            $display("                got      cx=%0d cy=%0d cz=%0d xi=%0d eta=%0d zeta=%0d deg=%0b",
                     got.cx, got.cy, got.cz, got.xi, got.eta, got.zeta, got.degen);
          end
        end
      end
    end
  end

  // Watchdog: a run that stops moving beats in either direction is stuck.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    tet_t t;
    int   n, block_idle;
    rst_ni = 1'b0;
    start = 1'b0;
    drive_p = '{default: '0};
    mismatches = 0;
    stray_results = 0;
    idle_cycles = 0;

    // Directed: all-zero and collinear shapes are degenerate, the unit
    // corner is the textbook case, extremes push the range and saturation.
    pending_tets.push_back(make_tet(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_tets.push_back(make_tet(0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1));
    pending_tets.push_back(make_tet(0, 0, 0, 2, 0, 0, 0, 2, 0, 0, 0, 2));
    pending_tets.push_back(make_tet(1, 1, 1, 2, 2, 2, 3, 3, 3, 4, 4, 4));
    pending_tets.push_back(make_tet(0, 0, 0, 5, 0, 0, 0, 5, 0, 3, 3, 0));
    pending_tets.push_back(make_tet(-32768, -32768, -32768, 32767, -32768, -32768,
                                    -32768, 32767, -32768, -32768, -32768, 32767));
    pending_tets.push_back(make_tet(32767, 32767, 32767, -32768, 32767, 32767,
                                    32767, -32768, 32767, 32767, 32767, -32768));
    pending_tets.push_back(make_tet(-32768, -32768, -32768, -32767, -32768, -32768,
                                    -32768, -32767, -32768, -32768, -32768, -32767));
    pending_tets.push_back(make_tet(32767, 32767, 32767, 32766, 32767, 32767,
                                    32767, 32766, 32767, 32767, 32767, 32766));
    // Nearly flat with long edges: tiny determinant, huge results.
    pending_tets.push_back(make_tet(-32768, 0, 0, 32767, 0, 0, 0, 32767, 0, 0, 1, 1));
    pending_tets.push_back(make_tet(0, 0, 0, 32767, 1, 0, -32768, 0, 1, 1, 32767, 0));
    pending_tets.push_back(make_tet(-1, -1, -1, 0, -1, -1, -1, 0, -1, -1, -1, 0));
    pending_tets.push_back(make_tet(100, -200, 300, -400, 500, -600, 700, -800, 900,
                                    -1000, 1100, -1300));
    pending_tets.push_back(make_tet(-3, 7, 11, 13, -17, 19, 23, 29, -31, 37, 41, 43));
    pending_tets.push_back(make_tet(0, 0, 0, 0, 0, 0, 1, 2, 3, 4, 5, 6));
    pending_tets.push_back(make_tet(32767, -32768, 32767, -32768, 32767, -32768,
                                    32767, 32767, -32768, -32768, -32768, 32767));
    t = make_tet(10, 20, 30, 40, 25, 30, 10, 60, 35, 12, 22, 90);
    t.drain = 1'b1;
    pending_tets.push_back(t);

    // Random part, in blocks of 40 that are each either back-to-back beats or
    // random idling, so gaps fall on every pipeline stage.
    block_idle = 0;
    for (n = 0; n < 850; n++) begin
      if (n % 40 == 0) begin
        block_idle = $urandom_range(1);
      end
      t = random_tet();
      t.gap = block_idle ? $urandom_range(19) : 0;
      t.drain = (n % 200 == 199);
      pending_tets.push_back(t);
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    do begin
      @(posedge clk_i);
    end while (pending_tets.size() != 0 || start || expected_centers.size() != 0);
    repeat (LATENCY + 10) @(posedge clk_i);

    if (mismatches == 0 && stray_results == 0 && expected_centers.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
